FILE: rtl/core/amr_refinement_error_norm_defines.svh
// Assertion macros shared by the refinement error norm RTL.
`ifndef AMR_REFINEMENT_ERROR_NORM_DEFINES_SVH
`define AMR_REFINEMENT_ERROR_NORM_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define AREN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("aren assertion failed");

// Next-cycle implication, checked outside reset.
`define AREN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("aren assertion failed");

`endif

FILE: rtl/core/aren_pkg.sv
// Package: word types, widths and register indexes of the refinement error norm.
package aren_pkg;

  localparam int VALUE_BITS = 32;
  localparam int MAX_EXTENT = 4096;
  localparam int POS_BITS   = 12;
  localparam int EXT_BITS   = 13;
  localparam int NORM_BITS  = 17;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 16;

  localparam logic [CFG_AW-1:0] CFG_USE_FIRST  = 3'd0;
  localparam logic [CFG_AW-1:0] CFG_ACT_DIMS   = 3'd1;
  localparam logic [CFG_AW-1:0] CFG_EXTENT_X   = 3'd2;
  localparam logic [CFG_AW-1:0] CFG_EXTENT_Y   = 3'd3;
  localparam logic [CFG_AW-1:0] CFG_EXTENT_Z   = 3'd4;
  localparam logic [CFG_AW-1:0] CFG_EPS_WEIGHT = 3'd5;

  typedef struct packed {
    logic signed [VALUE_BITS-1:0] center;
    logic signed [VALUE_BITS-1:0] x_minus;
    logic signed [VALUE_BITS-1:0] x_plus;
    logic signed [VALUE_BITS-1:0] y_minus;
    logic signed [VALUE_BITS-1:0] y_plus;
    logic signed [VALUE_BITS-1:0] z_minus;
    logic signed [VALUE_BITS-1:0] z_plus;
    logic [POS_BITS-1:0]          pos_x;
    logic [POS_BITS-1:0]          pos_y;
    logic [POS_BITS-1:0]          pos_z;
  } in_word_t;

  typedef struct packed {
    logic [NORM_BITS-1:0] error_norm;
    logic                 zero_denominator;
  } out_word_t;

endpackage

FILE: rtl/core/amr_refinement_error_norm.sv
// Top level: pipelined Lohner refinement error norm, one grid cell per word.
//
// Usage
//   in_*  : one stencil word per cell (center, six face neighbours, position).
//           A word is taken at a clock edge with in_valid high, in_stall low.
//   out_* : one result word per input word (error_norm Q1.16, zero_denominator),
//           taken at an edge with out_valid high and out_stall low.
//   cfg_* : plain register write port; the user must write it only while the
//           block is idle, as the block itself does not enforce it.
// Throughput: one word per cycle while out_stall is low. Pipeline: the
//   34 one-bit steps of the ratio divider and the 17 one-bit steps of the
//   square root, behind six front stages (edge terms, sums, eps product,
//   normalizing shift, squares, sums of squares) and the output register.
// Each stage holds its own valid bit and advances when it is empty or when
//   the stage after it advances, so bubbles close up and words keep flowing
//   while out_stall holds the output register; in_stall rises only when
//   every stage is full and out_stall holds the output register.
// Reset (synchronous, active low) empties the pipeline and loads the
//   register defaults: second-derivative mode, three dimensions, extents
//   4096, eps weight 655.
module amr_refinement_error_norm (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  aren_pkg::in_word_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output aren_pkg::out_word_t             out_data,
  input  logic                            cfg_we,
  input  logic [aren_pkg::CFG_AW-1:0]     cfg_addr,
  input  logic [aren_pkg::CFG_DW-1:0]     cfg_wdata
);
  import aren_pkg::*;

  localparam int VB     = VALUE_BITS;
  localparam int MW     = 36;           // N and D magnitude width
  localparam int SW     = 31;           // scaled magnitude width
  localparam int QB     = 34;           // ratio quotient bits
  localparam int RB     = NORM_BITS;    // root bits
  localparam int NFRONT = 6;
  localparam int NSTG   = NFRONT + QB + RB + 1;
  localparam int DIV0   = NFRONT;
  localparam int SQR0   = NFRONT + QB;
  localparam int OUTS   = NSTG - 1;

  // ---------------- configuration registers
  logic                use_first_r;
  logic [1:0]          act_dims_r;
  logic [EXT_BITS-1:0] ext_r [3];
  logic [15:0]         eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_first_r <= 1'b0;
      act_dims_r  <= 2'd3;
      ext_r[0]    <= EXT_BITS'(MAX_EXTENT);
      ext_r[1]    <= EXT_BITS'(MAX_EXTENT);
      ext_r[2]    <= EXT_BITS'(MAX_EXTENT);
      eps_r       <= 16'd655;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_USE_FIRST:  use_first_r <= cfg_wdata[0];
        CFG_ACT_DIMS:   act_dims_r  <= cfg_wdata[1:0];
        CFG_EXTENT_X:   ext_r[0]    <= cfg_wdata[EXT_BITS-1:0];
        CFG_EXTENT_Y:   ext_r[1]    <= cfg_wdata[EXT_BITS-1:0];
        CFG_EXTENT_Z:   ext_r[2]    <= cfg_wdata[EXT_BITS-1:0];
        CFG_EPS_WEIGHT: eps_r       <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // Active dimension mask; zero dimensions acts as one.
  logic [2:0] act_mask;
  always_comb begin
    case (act_dims_r)
      2'd2:    act_mask = 3'b011;
      2'd3:    act_mask = 3'b111;
      default: act_mask = 3'b001;
    endcase
  end

  // ---------------- stage handshake
  logic [NSTG-1:0] vld_r;
  logic [NSTG:0]   rdy;

  always_comb begin
    rdy[NSTG] = !out_stall;
    for (int i = NSTG - 1; i >= 0; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      if (rdy[0]) begin
        vld_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (rdy[i]) begin
          vld_r[i] <= vld_r[i-1];
        end
      end
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld_r[OUTS];

  // ---------------- stage 0: one-sided differences with edge replacement
  typedef struct packed {
    logic signed [VB:0] dp;
    logic signed [VB:0] dm;
    logic [VB-1:0]      mh;
    logic [VB-1:0]      ml;
  } s0_dim_t;

  s0_dim_t     s0_r [3];
  s0_dim_t     s0_nxt [3];
  logic [VB-1:0] s0_mc_r, s0_mc_nxt;

  always_comb begin
    logic signed [VB-1:0] lo [3];
    logic signed [VB-1:0] hi [3];
    logic [POS_BITS-1:0]  pos [3];
    logic [EXT_BITS-1:0]  ext;
    logic signed [VB:0]   dp, dm;
    logic signed [VB-1:0] c;
    c      = in_data.center;
    lo[0]  = in_data.x_minus;  hi[0] = in_data.x_plus;  pos[0] = in_data.pos_x;
    lo[1]  = in_data.y_minus;  hi[1] = in_data.y_plus;  pos[1] = in_data.pos_y;
    lo[2]  = in_data.z_minus;  hi[2] = in_data.z_plus;  pos[2] = in_data.pos_z;
    s0_mc_nxt = c[VB-1] ? VB'(-c) : VB'(c);
    for (int k = 0; k < 3; k++) begin
      ext = (ext_r[k] > EXT_BITS'(MAX_EXTENT)) ? EXT_BITS'(MAX_EXTENT) : ext_r[k];
      dp  = {hi[k][VB-1], hi[k]} - {c[VB-1], c};
      dm  = {c[VB-1], c} - {lo[k][VB-1], lo[k]};
      // low edge: reuse the inner difference, then the high edge likewise
      if (pos[k] == '0) dm = dp;
      if (ext != '0 && {1'b0, pos[k]} == ext - EXT_BITS'(1)) dp = dm;
      s0_nxt[k].dp = dp;
      s0_nxt[k].dm = dm;
      s0_nxt[k].mh = hi[k][VB-1] ? VB'(-hi[k]) : VB'(hi[k]);
      s0_nxt[k].ml = lo[k][VB-1] ? VB'(-lo[k]) : VB'(lo[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      s0_r    <= s0_nxt;
      s0_mc_r <= s0_mc_nxt;
    end
  end

  // ---------------- stage 1: numerator, base denominator, eps sum
  logic [MW-1:0] s1_n_r [3], s1_n_nxt [3];
  logic [MW-1:0] s1_db_r [3], s1_db_nxt [3];
  logic [VB+2:0] s1_s_r [3], s1_s_nxt [3];

  always_comb begin
    logic signed [VB+1:0] sum2;
    logic [VB:0]          adp, adm;
    for (int k = 0; k < 3; k++) begin
      adp = s0_r[k].dp[VB] ? (VB+1)'(-s0_r[k].dp) : (VB+1)'(s0_r[k].dp);
      adm = s0_r[k].dm[VB] ? (VB+1)'(-s0_r[k].dm) : (VB+1)'(s0_r[k].dm);
      if (use_first_r) begin
        sum2         = {s0_r[k].dp[VB], s0_r[k].dp} + {s0_r[k].dm[VB], s0_r[k].dm};
        s1_db_nxt[k] = MW'(s0_r[k].mh) + MW'(s0_r[k].ml);
      end else begin
        sum2         = {s0_r[k].dp[VB], s0_r[k].dp} - {s0_r[k].dm[VB], s0_r[k].dm};
        s1_db_nxt[k] = MW'(adp) + MW'(adm);
      end
      s1_n_nxt[k] = sum2[VB+1] ? MW'(-sum2) : MW'(sum2);
      s1_s_nxt[k] = {s0_mc_r, 1'b0} + (VB+3)'(s0_r[k].mh) + (VB+3)'(s0_r[k].ml);
      if (!act_mask[k]) begin
        s1_n_nxt[k]  = '0;
        s1_db_nxt[k] = '0;
        s1_s_nxt[k]  = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_n_r  <= s1_n_nxt;
      s1_db_r <= s1_db_nxt;
      s1_s_r  <= s1_s_nxt;
    end
  end

  // ---------------- stage 2: eps product and full denominator
  logic [MW-1:0] s2_n_r [3];
  logic [MW-1:0] s2_d_r [3], s2_d_nxt [3];

  always_comb begin
    logic [VB+18:0] prod;
    for (int k = 0; k < 3; k++) begin
      prod        = (VB+19)'(s1_s_r[k]) * (VB+19)'(eps_r);
      s2_d_nxt[k] = s1_db_r[k] + (use_first_r ? '0 : MW'(prod[VB+18:16]));
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      s2_n_r <= s1_n_r;
      s2_d_r <= s2_d_nxt;
    end
  end

  // ---------------- stage 3: common normalizing shift
  logic [SW-1:0] s3_a_r [3], s3_a_nxt [3];
  logic [SW-1:0] s3_e_r [3], s3_e_nxt [3];
  logic          s3_zd_r, s3_zd_nxt;

  always_comb begin
    logic [MW-1:0] mx;
    logic [2:0]    sh;
    mx = '0;
    s3_zd_nxt = 1'b1;
    for (int k = 0; k < 3; k++) begin
      if (s2_d_r[k] != '0) s3_zd_nxt = 1'b0;
      if (s2_n_r[k] > mx) mx = s2_n_r[k];
      if (s2_d_r[k] > mx) mx = s2_d_r[k];
    end
    sh = '0;
    for (int b = SW; b < MW; b++) begin
      if (mx[b]) sh = 3'(b - SW + 1);
    end
    for (int k = 0; k < 3; k++) begin
      s3_a_nxt[k] = SW'(s2_n_r[k] >> sh);
      s3_e_nxt[k] = SW'(s2_d_r[k] >> sh);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      s3_a_r  <= s3_a_nxt;
      s3_e_r  <= s3_e_nxt;
      s3_zd_r <= s3_zd_nxt;
    end
  end

  // ---------------- stage 4: squares
  logic [2*SW-1:0] s4_na_r [3];
  logic [2*SW-1:0] s4_de_r [3];
  logic            s4_zd_r;

  always_ff @(posedge clk) begin
    if (rdy[4]) begin
      for (int k = 0; k < 3; k++) begin
        s4_na_r[k] <= s3_a_r[k] * s3_a_r[k];
        s4_de_r[k] <= s3_e_r[k] * s3_e_r[k];
      end
      s4_zd_r <= s3_zd_r;
    end
  end

  // ---------------- stage 5: sums of squares
  logic [63:0] s5_sn_r, s5_sd_r;
  logic        s5_zd_r;

  always_ff @(posedge clk) begin
    if (rdy[5]) begin
      s5_sn_r <= 64'(s4_na_r[0]) + 64'(s4_na_r[1]) + 64'(s4_na_r[2]);
      s5_sd_r <= 64'(s4_de_r[0]) + 64'(s4_de_r[1]) + 64'(s4_de_r[2]);
      s5_zd_r <= s4_zd_r;
    end
  end

  // ---------------- ratio divider: one quotient bit per stage
  // Divides sn * 2^34 by 4 * sd; sn below 4 * sd keeps the quotient in 34 bits.
  typedef struct packed {
    logic          zd;
    logic          sat;
    logic [66:0]   rem;
    logic [65:0]   dsh;
    logic [QB-1:0] q;
  } div_t;

  div_t div_r [QB];
  div_t div_in [QB];

  assign div_in[0] = '{zd: s5_zd_r, sat: (s5_sd_r == '0), rem: 67'(s5_sn_r),
                       dsh: {s5_sd_r, 2'b00}, q: '0};

  for (genvar j = 0; j < QB; j++) begin : g_div
    div_t st_nxt;
    if (j > 0) begin : g_link
      assign div_in[j] = div_r[j-1];
    end
    always_comb begin
      logic [66:0] r2;
      logic        ge;
      r2 = {div_in[j].rem[65:0], 1'b0};
      ge = r2 >= {1'b0, div_in[j].dsh};
      st_nxt     = div_in[j];
      st_nxt.rem = ge ? r2 - {1'b0, div_in[j].dsh} : r2;
      st_nxt.q   = {div_in[j].q[QB-2:0], ge};
      // an integer part of four or more saturates the norm
      if (j == 0 && {3'b000, s5_sn_r} >= {1'b0, s5_sd_r, 2'b00}) st_nxt.sat = 1'b1;
    end
    always_ff @(posedge clk) begin
      if (rdy[DIV0+j]) begin
        div_r[j] <= st_nxt;
      end
    end
  end

  // ---------------- square root: one root bit per stage, square tracked by adds
  typedef struct packed {
    logic          zd;
    logic          sat;
    logic [QB-1:0] rad;
    logic [RB-1:0] root;
    logic [QB-1:0] sq;
  } sqr_t;

  sqr_t sqr_r [RB];
  sqr_t sqr_in [RB];

  assign sqr_in[0] = '{zd: div_r[QB-1].zd, sat: div_r[QB-1].sat, rad: div_r[QB-1].q,
                       root: '0, sq: '0};

  for (genvar k = 0; k < RB; k++) begin : g_sqr
    localparam int B = RB - 1 - k;
    sqr_t st_nxt;
    if (k > 0) begin : g_link
      assign sqr_in[k] = sqr_r[k-1];
    end
    always_comb begin
      logic [QB+1:0] t2;
      t2 = (QB+2)'(sqr_in[k].sq) + ((QB+2)'(sqr_in[k].root) << (B + 1))
           + ((QB+2)'(1) << (2 * B));
      st_nxt = sqr_in[k];
      if (t2 <= (QB+2)'(sqr_in[k].rad)) begin
        st_nxt.root = sqr_in[k].root | (RB'(1) << B);
        st_nxt.sq   = t2[QB-1:0];
      end
    end
    always_ff @(posedge clk) begin
      if (rdy[SQR0+k]) begin
        sqr_r[k] <= st_nxt;
      end
    end
  end

  // ---------------- output register
  out_word_t out_r;

  always_ff @(posedge clk) begin
    if (rdy[OUTS]) begin
      out_r.zero_denominator <= sqr_r[RB-1].zd;
      if (sqr_r[RB-1].zd) begin
        out_r.error_norm <= '0;
      end else if (sqr_r[RB-1].sat) begin
        out_r.error_norm <= '1;
      end else begin
        out_r.error_norm <= sqr_r[RB-1].root;
      end
    end
  end

  assign out_data = out_r;

  // ---------------- assertions
`include "amr_refinement_error_norm_defines.svh"

  `AREN_ASSERT_IMP(a_zd_forces_zero, out_valid && out_data.zero_denominator, out_data.error_norm == '0)
  `AREN_ASSERT_NXT(a_accept_fills_first, in_valid && !in_stall, vld_r[0])
  `AREN_ASSERT_IMP(a_stall_only_when_full, in_stall, vld_r[0])

endmodule
